/* src/svm_pkg.sv */
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types and constants of the supply voltage monitor: field widths,
// the fixed-point scaling constants, register codes and control structs.
// ----------------------------------------------------------------------------
package svm_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int MV_W      = 16;
	localparam int SUM_W     = 16;
	localparam int THR_W     = 16;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	localparam int RCP_SHIFT = 20;
	localparam int RCP_W     = RCP_SHIFT + 1;
	localparam int RCP_PROD_W = SUM_W + RCP_W;
	localparam int CHK_W     = 21;

	localparam int SCALED_W  = 28;
	localparam int MV_SCALE  = 56100;
	localparam int MV_ROUND  = 2048;
	localparam int MV_FRAC   = 12;
	localparam int MV_OFFSET = 286;

	localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST = 12'd4000;
	localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST  = 12'd10;
	localparam logic [THR_W-1:0]    LOW_THR_RST    = 16'd0;

	typedef enum logic [1:0] {
		REG_RANGE_HIGH = 2'd0,
		REG_RANGE_LOW  = 2'd1,
		REG_LOW_THR    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] range_high;
		logic [SAMPLE_W-1:0] range_low;
		logic [THR_W-1:0]    low_thr;
	} cfg_t;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

endpackage

/* src/svm_regs.sv */
// ----------------------------------------------------------------------------
// svm_regs
// APB register file holding the out-of-range window and the low-voltage
// threshold.
// ----------------------------------------------------------------------------
module svm_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [svm_pkg::APB_AW-1:0]    paddr,
	input  logic [svm_pkg::APB_DW-1:0]    pwdata,
	output logic [svm_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output svm_pkg::cfg_t                 cfg
);

	svm_pkg::cfg_t     cfg_q;
	svm_pkg::reg_idx_t idx;
	logic              wr;

	assign idx    = svm_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_high <= svm_pkg::RANGE_HIGH_RST;
			cfg_q.range_low  <= svm_pkg::RANGE_LOW_RST;
			cfg_q.low_thr    <= svm_pkg::LOW_THR_RST;
		end else if (wr) begin
			unique case (idx)
				svm_pkg::REG_RANGE_HIGH: cfg_q.range_high <= pwdata[svm_pkg::SAMPLE_W-1:0];
				svm_pkg::REG_RANGE_LOW:  cfg_q.range_low  <= pwdata[svm_pkg::SAMPLE_W-1:0];
				svm_pkg::REG_LOW_THR:    cfg_q.low_thr    <= pwdata[svm_pkg::THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			svm_pkg::REG_RANGE_HIGH: prdata = svm_pkg::APB_DW'(cfg_q.range_high);
			svm_pkg::REG_RANGE_LOW:  prdata = svm_pkg::APB_DW'(cfg_q.range_low);
			svm_pkg::REG_LOW_THR:    prdata = svm_pkg::APB_DW'(cfg_q.low_thr);
			default:                 prdata = '0;
		endcase
	end

endmodule

/* src/svm_ring.sv */
// ----------------------------------------------------------------------------
// svm_ring
// Sample ring memory with registered read, per-entry valid bits
// that make unwritten entries read as zero, and write-to-read forwarding.
// ----------------------------------------------------------------------------
module svm_ring #(
	parameter int WINDOW = 10,
	parameter int SLOT_W = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [SLOT_W-1:0]             rd_addr,
	input  logic                          wr_en,
	input  logic [SLOT_W-1:0]             wr_addr,
	input  logic [svm_pkg::SAMPLE_W-1:0]  wr_data,
	output logic [svm_pkg::SAMPLE_W-1:0]  old_data
);

	logic [svm_pkg::SAMPLE_W-1:0] mem [WINDOW];
	logic [WINDOW-1:0]            vld_q;
	logic [svm_pkg::SAMPLE_W-1:0] rdata_q;
	logic [svm_pkg::SAMPLE_W-1:0] fdata_q;
	logic                         rvld_q;
	logic                         fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
			fdata_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
			fwd_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
				fwd_q  <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	assign old_data = fwd_q ? fdata_q : (rvld_q ? rdata_q : '0);

endmodule

/* src/svm_scale.sv */
// ----------------------------------------------------------------------------
// svm_scale
// Divides the window sum by the window length through a reciprocal multiply
// with one correction step, then multiplies the mean by the millivolt scale.
// ----------------------------------------------------------------------------
module svm_scale #(
	parameter int WINDOW = 10
) (
	input  logic                          clk,
	input  svm_pkg::pipe_en_t             en,
	input  logic [svm_pkg::SUM_W-1:0]     sum_s2,
	output logic [svm_pkg::SCALED_W-1:0]  scaled_s5
);

	localparam logic [svm_pkg::RCP_W-1:0] Rcp =
		svm_pkg::RCP_W'((64'd1 << svm_pkg::RCP_SHIFT) / WINDOW);

	logic [svm_pkg::RCP_PROD_W-1:0] prod_s3;
	logic [svm_pkg::SUM_W-1:0]      sum_s3;
	logic [svm_pkg::SAMPLE_W-1:0]   mean_s4;
	logic [svm_pkg::SUM_W-1:0]      q0;
	logic [svm_pkg::CHK_W-1:0]      qw;
	logic [svm_pkg::CHK_W-1:0]      rem;
	logic [svm_pkg::SUM_W-1:0]      mean;

	assign q0   = prod_s3[svm_pkg::RCP_SHIFT +: svm_pkg::SUM_W];
	assign qw   = svm_pkg::CHK_W'(q0) * svm_pkg::CHK_W'(WINDOW);
	assign rem  = svm_pkg::CHK_W'(sum_s3) - qw;
	assign mean = (rem >= svm_pkg::CHK_W'(WINDOW)) ? q0 + 1'b1 : q0;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_s3 <= svm_pkg::RCP_PROD_W'(sum_s2) * svm_pkg::RCP_PROD_W'(Rcp);
			sum_s3  <= sum_s2;
		end
		if (en.s4) begin
			mean_s4 <= mean[svm_pkg::SAMPLE_W-1:0];
		end
		if (en.s5) begin
			scaled_s5 <= svm_pkg::SCALED_W'(mean_s4)
				* svm_pkg::SCALED_W'(svm_pkg::MV_SCALE);
		end
	end

endmodule

/* src/supply_voltage_monitor.sv */
// ----------------------------------------------------------------------------
// supply_voltage_monitor
// Throughput: one item per cycle while the output is not stalled; the ring memory is read on accept and
// written back as the item leaves the first stage, with forwarding between the two.
// Reset clears the registers to their defaults, the ring valid bits, the
// running sum, the write slot and the held result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module supply_voltage_monitor #(
	parameter int WINDOW = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [svm_pkg::APB_AW-1:0]    paddr,
	input  logic [svm_pkg::APB_DW-1:0]    pwdata,
	output logic [svm_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          sample_ready,
	input  logic [svm_pkg::SAMPLE_W-1:0]  sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [svm_pkg::MV_W-1:0]      voltage_mv,
	output logic                          low_voltage,
	output logic                          out_of_range,
	output logic                          timed_out
);

	localparam int SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	svm_pkg::cfg_t     cfg;
	svm_pkg::pipe_en_t en;

	logic acc;
	logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
	logic leave1, leave2, leave3, leave4, leave5;
	logic can1, can2, can3, can4, can5, can_out;

	logic [SlotW-1:0]             wslot_q;
	logic [svm_pkg::SUM_W-1:0]    sum_q;
	logic [svm_pkg::SUM_W-1:0]    sum_new;
	logic [svm_pkg::SAMPLE_W-1:0] old_data;
	logic                         wr_en;

	logic                         rdy_s1, rng_s1;
	logic [svm_pkg::SAMPLE_W-1:0] smp_s1;
	logic [SlotW-1:0]             slot_s1;
	logic                         rdy_s2, rng_s2;
	logic [svm_pkg::SUM_W-1:0]    sum_s2;
	logic                         rdy_s3, rng_s3, rdy_s4, rng_s4, rdy_s5, rng_s5;
	logic [svm_pkg::SCALED_W-1:0] scaled_s5;
	logic [svm_pkg::SCALED_W-1:0] rounded;
	logic [svm_pkg::MV_W:0]       mv_wide;
	logic [svm_pkg::MV_W-1:0]     mv;

	logic [svm_pkg::MV_W-1:0]     volt_q;
	logic                         low_q, rng_q, tmo_q;

	svm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign can_out = !out_valid_q || !out_stall;
	assign leave5  = v5_q && can_out;
	assign can5    = !v5_q || leave5;
	assign leave4  = v4_q && can5;
	assign can4    = !v4_q || leave4;
	assign leave3  = v3_q && can4;
	assign can3    = !v3_q || leave3;
	assign leave2  = v2_q && can3;
	assign can2    = !v2_q || leave2;
	assign leave1  = v1_q && can2;
	assign can1    = !v1_q || leave1;
	assign in_stall = !can1;
	assign acc     = in_valid && can1;

	assign wr_en   = leave1 && rdy_s1;
	assign sum_new = sum_q - svm_pkg::SUM_W'(old_data) + svm_pkg::SUM_W'(smp_s1);

	svm_ring #(
		.WINDOW (WINDOW),
		.SLOT_W (SlotW)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (acc),
		.rd_addr  (wslot_q),
		.wr_en    (wr_en),
		.wr_addr  (slot_s1),
		.wr_data  (smp_s1),
		.old_data (old_data)
	);

	assign en.s3 = leave2;
	assign en.s4 = leave3;
	assign en.s5 = leave4;

	svm_scale #(
		.WINDOW (WINDOW)
	) u_scale (
		.clk       (clk),
		.en        (en),
		.sum_s2    (sum_s2),
		.scaled_s5 (scaled_s5)
	);

	assign rounded = scaled_s5 + svm_pkg::SCALED_W'(svm_pkg::MV_ROUND);
	assign mv_wide = (svm_pkg::MV_W+1)'(rounded >> svm_pkg::MV_FRAC)
		+ (svm_pkg::MV_W+1)'(svm_pkg::MV_OFFSET);
	assign mv      = mv_wide[svm_pkg::MV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			v4_q        <= 1'b0;
			v5_q        <= 1'b0;
			out_valid_q <= 1'b0;
			wslot_q     <= '0;
			sum_q       <= '0;
			volt_q      <= '0;
			low_q       <= 1'b0;
			rng_q       <= 1'b0;
			tmo_q       <= 1'b0;
		end else begin
			v1_q        <= acc    || (v1_q && !leave1);
			v2_q        <= leave1 || (v2_q && !leave2);
			v3_q        <= leave2 || (v3_q && !leave3);
			v4_q        <= leave3 || (v4_q && !leave4);
			v5_q        <= leave4 || (v5_q && !leave5);
			out_valid_q <= leave5 || (out_valid_q && out_stall);
			if (acc && sample_ready) begin
				wslot_q <= (wslot_q == SlotW'(WINDOW - 1)) ? '0 : wslot_q + 1'b1;
			end
			if (wr_en) begin
				sum_q <= sum_new;
			end
			if (leave5) begin
				if (rdy_s5) begin
					volt_q <= mv;
					low_q  <= mv < cfg.low_thr;
					rng_q  <= rng_s5;
					tmo_q  <= 1'b0;
				end else begin
					tmo_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rdy_s1  <= sample_ready;
			smp_s1  <= sample;
			slot_s1 <= wslot_q;
			rng_s1  <= (sample > cfg.range_high) || (sample < cfg.range_low);
		end
		if (leave1) begin
			rdy_s2 <= rdy_s1;
			rng_s2 <= rng_s1;
			sum_s2 <= sum_new;
		end
		if (leave2) begin
			rdy_s3 <= rdy_s2;
			rng_s3 <= rng_s2;
		end
		if (leave3) begin
			rdy_s4 <= rdy_s3;
			rng_s4 <= rng_s3;
		end
		if (leave4) begin
			rdy_s5 <= rdy_s4;
			rng_s5 <= rng_s4;
		end
	end

	assign out_valid    = out_valid_q;
	assign voltage_mv   = volt_q;
	assign low_voltage  = low_q;
	assign out_of_range = rng_q;
	assign timed_out    = tmo_q;

endmodule

/* src/svm_checker.sv */
// ----------------------------------------------------------------------------
// svm_checker
// Port-level checks of the supply voltage monitor, bound to the top level.
// ----------------------------------------------------------------------------
module svm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [svm_pkg::MV_W-1:0]      voltage_mv,
	input logic                          timed_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(voltage_mv))
		else $error("Stalled item was dropped or changed.");

	a_mv_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !timed_out |-> voltage_mv >= 16'd286)
		else $error("Measured voltage lies below the scale offset.");

	a_mv_ceil: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !timed_out |-> voltage_mv <= 16'd56372)
		else $error("Measured voltage lies above the full-scale value.");

endmodule

bind supply_voltage_monitor svm_checker u_svm_checker (.*);

/* dv/tb_supply_voltage_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_supply_voltage_monitor
// Self-checking bench for the averaging supply voltage monitor. Ticks with and
// without a conversion are pushed through the valid/stall input while the
// output side stalls at random; a local model of the ten-entry ring, the
// running sum, the millivolt scaling and the held flags predicts every result.
// Window and threshold registers are rewritten over APB between drained phases.
// ----------------------------------------------------------------------------
module tb_supply_voltage_monitor;

	localparam int RING_DEPTH     = 10;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RAND_PHASES    = 8;
	localparam int PHASE_TICKS    = 110;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic                         rdy;
		logic [svm_pkg::SAMPLE_W-1:0] smp;
	} tick_t;

	typedef struct packed {
		logic [svm_pkg::MV_W-1:0] mv;
		logic                     low;
		logic                     oor;
		logic                     tmo;
	} reading_t;

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         psel         = 1'b0;
	logic                         penable      = 1'b0;
	logic                         pwrite       = 1'b0;
	logic [svm_pkg::APB_AW-1:0]   paddr        = '0;
	logic [svm_pkg::APB_DW-1:0]   pwdata       = '0;
	logic [svm_pkg::APB_DW-1:0]   prdata;
	logic                         pready;
	logic                         in_valid     = 1'b0;
	logic                         in_stall;
	logic                         sample_ready = 1'b0;
	logic [svm_pkg::SAMPLE_W-1:0] sample       = '0;
	logic                         out_valid;
	logic                         out_stall    = 1'b0;
	logic [svm_pkg::MV_W-1:0]     voltage_mv;
	logic                         low_voltage;
	logic                         out_of_range;
	logic                         timed_out;

	supply_voltage_monitor #(
		.WINDOW(RING_DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_ready(sample_ready),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.voltage_mv  (voltage_mv),
		.low_voltage (low_voltage),
		.out_of_range(out_of_range),
		.timed_out   (timed_out)
	);

	tick_t    tick_q[$];
	reading_t reading_q[$];
	tick_t    next_tick;
	reading_t want;
	reading_t got;

	logic [svm_pkg::SAMPLE_W-1:0] cfg_high = svm_pkg::RANGE_HIGH_RST;
	logic [svm_pkg::SAMPLE_W-1:0] cfg_low  = svm_pkg::RANGE_LOW_RST;
	logic [svm_pkg::THR_W-1:0]    cfg_thr  = svm_pkg::LOW_THR_RST;

	logic [svm_pkg::SAMPLE_W-1:0] ring[RING_DEPTH];
	int                           slot     = 0;
	logic [svm_pkg::SUM_W-1:0]    ring_sum = '0;
	reading_t                     held     = '0;

	int idle_pct  = 0;
	int stall_pct = 0;
	int errors    = 0;
	int quiet     = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [svm_pkg::MV_W-1:0] mv_of(
		input logic [svm_pkg::SUM_W-1:0] mean);
		logic [31:0] scaled;
		scaled = 32'(mean) * 32'd56100 + 32'd2048;
		return svm_pkg::MV_W'((scaled >> 12) + 32'd286);
	endfunction

	function automatic void predict_tick(input logic rdy,
		input logic [svm_pkg::SAMPLE_W-1:0] smp);
		if (rdy) begin
			held.oor = (smp > cfg_high) || (smp < cfg_low);
			ring_sum = ring_sum - svm_pkg::SUM_W'(ring[slot]) + svm_pkg::SUM_W'(smp);
			ring[slot] = smp;
			slot = (slot == RING_DEPTH - 1) ? 0 : slot + 1;
			held.mv = mv_of(svm_pkg::SUM_W'(ring_sum / RING_DEPTH));
			held.low = held.mv < cfg_thr;
			held.tmo = 1'b0;
		end else begin
			held.tmo = 1'b1;
		end
		reading_q.push_back(held);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	// Input side: a presented item holds until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_tick(sample_ready, sample);
			end
			if (!in_valid || !in_stall) begin
				if (tick_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					next_tick = tick_q.pop_front();
					in_valid <= 1'b1;
					sample_ready <= next_tick.rdy;
					sample <= next_tick.smp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: check each taken result against the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{voltage_mv, low_voltage, out_of_range, timed_out};
				if (reading_q.size() == 0) begin
					report_mismatch($sformatf("result %p with nothing expected", got));
				end else begin
					want = reading_q.pop_front();
					if (got.mv !== want.mv)
						report_mismatch($sformatf("voltage_mv %0d, expected %0d",
							got.mv, want.mv));
					if (got.low !== want.low)
						report_mismatch($sformatf("low_voltage %b, expected %b",
							got.low, want.low));
					if (got.oor !== want.oor)
						report_mismatch($sformatf("out_of_range %b, expected %b",
							got.oor, want.oor));
					if (got.tmo !== want.tmo)
						report_mismatch($sformatf("timed_out %b, expected %b",
							got.tmo, want.tmo));
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("tb_supply_voltage_monitor failed");
			$finish;
		end
	end

	task automatic apb_write(input logic [1:0] idx,
		input logic [svm_pkg::APB_DW-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			svm_pkg::REG_RANGE_HIGH: cfg_high = data[svm_pkg::SAMPLE_W-1:0];
			svm_pkg::REG_RANGE_LOW:  cfg_low  = data[svm_pkg::SAMPLE_W-1:0];
			svm_pkg::REG_LOW_THR:    cfg_thr  = data[svm_pkg::THR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (tick_q.size() != 0 || in_valid || reading_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void push_tick(input logic rdy,
		input logic [svm_pkg::SAMPLE_W-1:0] smp);
		tick_t t;
		t.rdy = rdy;
		t.smp = smp;
		tick_q.push_back(t);
	endfunction

	function automatic logic [svm_pkg::SAMPLE_W-1:0] near(
		input logic [svm_pkg::SAMPLE_W-1:0] bound);
		int v;
		v = int'(bound) + int'($urandom_range(6)) - 3;
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return svm_pkg::SAMPLE_W'(v);
	endfunction

	function automatic logic [svm_pkg::SAMPLE_W-1:0] random_sample();
		case ($urandom_range(4))
			0: return near(cfg_low);
			1: return near(cfg_high);
			2: return $urandom_range(1) ? 12'hFFF : 12'h000;
			3: return svm_pkg::SAMPLE_W'($urandom_range(3000, 4095));
			default: return svm_pkg::SAMPLE_W'($urandom());
		endcase
	endfunction

	task automatic random_config();
		logic [svm_pkg::SAMPLE_W-1:0] a;
		logic [svm_pkg::SAMPLE_W-1:0] b;
		logic [svm_pkg::THR_W-1:0]    thr;
		a = svm_pkg::SAMPLE_W'($urandom());
		b = svm_pkg::SAMPLE_W'($urandom());
		case ($urandom_range(3))
			0: begin
				apb_write(svm_pkg::REG_RANGE_HIGH,
					svm_pkg::APB_DW'({$urandom(), a > b ? a : b}));
				apb_write(svm_pkg::REG_RANGE_LOW,
					svm_pkg::APB_DW'({$urandom(), a > b ? b : a}));
			end
			1: begin
				apb_write(svm_pkg::REG_RANGE_HIGH, 32'hFFF);
				apb_write(svm_pkg::REG_RANGE_LOW, 32'h0);
			end
			2: begin
				apb_write(svm_pkg::REG_RANGE_HIGH, 32'(a));
				apb_write(svm_pkg::REG_RANGE_LOW, 32'(b));
			end
			default: begin
				apb_write(svm_pkg::REG_RANGE_HIGH, 32'(a));
				apb_write(svm_pkg::REG_RANGE_LOW, 32'(a));
			end
		endcase
		case ($urandom_range(5))
			0: thr = '0;
			1: thr = '1;
			default: thr = mv_of(svm_pkg::SUM_W'($urandom_range(4095)))
				+ svm_pkg::THR_W'($urandom_range(100)) - 16'd50;
		endcase
		apb_write(svm_pkg::REG_LOW_THR, svm_pkg::APB_DW'({$urandom(), thr}));
	endtask

	initial begin
		int p;
		int n;
		for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: window boundaries, warm-up and timeouts that hold the last result.
		push_tick(1'b1, 12'd0);
		push_tick(1'b1, 12'd4095);
		push_tick(1'b1, 12'd10);
		push_tick(1'b1, 12'd4000);
		push_tick(1'b1, 12'd9);
		push_tick(1'b1, 12'd4001);
		push_tick(1'b0, 12'hFFF);
		push_tick(1'b0, 12'h000);
		push_tick(1'b1, 12'd2048);
		push_tick(1'b1, 12'hAAA);
		push_tick(1'b1, 12'h555);
		wait_drained();

		// Crossed window, top threshold, upper data bits set, unknown register.
		apb_write(svm_pkg::REG_RANGE_HIGH, 32'hFFFF_F000);
		apb_write(svm_pkg::REG_RANGE_LOW, 32'hABCD_EFFF);
		apb_write(svm_pkg::REG_LOW_THR, 32'h5A5A_FFFF);
		apb_write(REG_UNUSED, 32'h0000_0123);
		push_tick(1'b1, 12'd0);
		push_tick(1'b0, 12'd7);
		for (int i = 0; i < RING_DEPTH; i++) push_tick(1'b1, 12'd4095);
		push_tick(1'b1, 12'd1);
		wait_drained();

		for (p = 0; p < RAND_PHASES; p++) begin
			random_config();
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 61; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 61; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			for (n = 0; n < PHASE_TICKS; n++) begin
				push_tick($urandom_range(99) >= 12, random_sample());
			end
			wait_drained();
		end

		if (errors == 0) begin
			$display("tb_supply_voltage_monitor passed");
		end else begin
			$display("tb_supply_voltage_monitor failed");
		end
		$finish;
	end

endmodule
